### rtl/core/pattern_change_debouncer_unit_macros.svh
// Assertion macros for the pattern change debouncer
`ifndef PATTERN_CHANGE_DEBOUNCER_UNIT_MACROS_SVH
`define PATTERN_CHANGE_DEBOUNCER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pcd_pkg.sv
// Types and constants shared by the pattern change debouncer modules
package pcd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned PatW     = 3;
  localparam int unsigned CountW   = 8;
  localparam int unsigned SpacingW = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [PatW-1:0]   PAT_UNKNOWN    = 3'd0;
  localparam logic [PatW-1:0]   PAT_SLOW_BLINK = 3'd3;
  localparam logic [PatW-1:0]   PAT_FAST_BLINK = 3'd4;
  localparam logic [CountW-1:0] COUNT_MAX      = 8'd255;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_QUIET_SPACING = 2'd0;
  localparam logic [1:0] REG_BLINK_POLLS   = 2'd1;
  localparam logic [1:0] REG_QUIET_POLLS   = 2'd2;

  localparam logic [SpacingW-1:0] QUIET_SPACING_RST = 16'd30;
  localparam logic [CountW-1:0]   BLINK_POLLS_RST   = 8'd1;
  localparam logic [CountW-1:0]   QUIET_POLLS_RST   = 8'd2;

  typedef struct packed {
    logic [SpacingW-1:0] quiet_spacing;
    logic [CountW-1:0]   blink_polls;
    logic [CountW-1:0]   quiet_polls;
  } pcd_cfg_t;

  // last report time doubles as last change time: both are set together
  typedef struct packed {
    logic [PatW-1:0]   cand_pat;
    logic [CountW-1:0] cand_cnt;
    logic [PatW-1:0]   report;
    logic [TimeW-1:0]  chg_time;
  } pcd_state_t;

endpackage

### rtl/core/pattern_change_debouncer_unit.sv
// Pattern change debouncer: top level with input word register, result register and APB port
// One poll word per cycle in while no stall holds it, one result word per poll out.
// A poll waits in the input register, is evaluated by a single pass of compares and
// two 32-bit subtracts, and lands in the result register together with the state
// update. The sustained rate is one word per clock; the only limit is the result
// register, whose stall backs up the input after one further word. The result carries
// the change flag plus the currently reported pattern and the time of the last accepted
// change. Registers: 0x0 quiet spacing (ms), 0x4 blink stable polls, 0x8 quiet stable
// polls; write them only while no poll is in flight.
module pattern_change_debouncer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pcd_pkg::TimeW-1:0]     in_now_ms,
  input  logic [pcd_pkg::PatW-1:0]      in_pattern,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_changed,
  output logic [pcd_pkg::PatW-1:0]      out_reported_pattern,
  output logic [pcd_pkg::TimeW-1:0]     out_change_time_ms,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pcd_pkg::AddrW-1:0]     cfg_paddr,
  input  logic [pcd_pkg::DataW-1:0]     cfg_pwdata,
  output logic [pcd_pkg::DataW-1:0]     cfg_prdata,
  output logic                          cfg_pready
);

  pcd_pkg::pcd_cfg_t               cfg_r;
  pcd_pkg::pcd_state_t             state_r;
  pcd_pkg::pcd_state_t             state_nxt;
  logic                            s1_valid_r;
  logic [pcd_pkg::TimeW-1:0]       s1_now_r;
  logic [pcd_pkg::PatW-1:0]        s1_pat_r;
  logic                            out_valid_r;
  logic                            out_changed_r;
  logic                            changed;
  logic                            advance;
  logic                            in_take;
  logic                            cfg_wr;
  logic [1:0]                      reg_idx;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_spacing <= pcd_pkg::QUIET_SPACING_RST;
      cfg_r.blink_polls   <= pcd_pkg::BLINK_POLLS_RST;
      cfg_r.quiet_polls   <= pcd_pkg::QUIET_POLLS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        pcd_pkg::REG_QUIET_SPACING: cfg_r.quiet_spacing <= cfg_pwdata[pcd_pkg::SpacingW-1:0];
        pcd_pkg::REG_BLINK_POLLS:   cfg_r.blink_polls   <= cfg_pwdata[pcd_pkg::CountW-1:0];
        pcd_pkg::REG_QUIET_POLLS:   cfg_r.quiet_polls   <= cfg_pwdata[pcd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pcd_pkg::REG_QUIET_SPACING:
        cfg_prdata = {{(pcd_pkg::DataW-pcd_pkg::SpacingW){1'b0}}, cfg_r.quiet_spacing};
      pcd_pkg::REG_BLINK_POLLS:
        cfg_prdata = {{(pcd_pkg::DataW-pcd_pkg::CountW){1'b0}}, cfg_r.blink_polls};
      pcd_pkg::REG_QUIET_POLLS:
        cfg_prdata = {{(pcd_pkg::DataW-pcd_pkg::CountW){1'b0}}, cfg_r.quiet_polls};
      default:
        cfg_prdata = '0;
    endcase
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r <= in_now_ms;
      s1_pat_r <= in_pattern;
    end
  end

  pcd_eval u_eval (
    .cfg       (cfg_r),
    .state     (state_r),
    .now_ms    (s1_now_r),
    .pattern   (s1_pat_r),
    .state_nxt (state_nxt),
    .changed   (changed)
  );

  // state moves only when the word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.cand_pat <= pcd_pkg::PAT_UNKNOWN;
      state_r.cand_cnt <= '0;
      state_r.report   <= pcd_pkg::PAT_UNKNOWN;
      state_r.chg_time <= '0;
    end else if (advance && s1_valid_r) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_changed_r <= changed;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_changed          = out_changed_r;
  // state only advances with a new result, so it is the held result's view
  assign out_reported_pattern = state_r.report;
  assign out_change_time_ms   = state_r.chg_time;

`include "pattern_change_debouncer_unit_macros.svh"

  `PCD_ASSERT_NOW(a_change_follows_cand, out_valid_r && out_changed_r, state_r.report == state_r.cand_pat, "reported pattern differs from candidate right after a change")
  `PCD_ASSERT_NEXT(a_cnt_nonzero, advance && s1_valid_r, state_r.cand_cnt != '0, "candidate count zero after a poll")
  `PCD_ASSERT_NEXT(a_state_held, out_valid_r && out_stall, $stable(state_r), "state moved while result stalled")

endmodule

### rtl/core/pcd_eval.sv
// Next-state logic of the debouncer for one poll
module pcd_eval (
  input  pcd_pkg::pcd_cfg_t              cfg,
  input  pcd_pkg::pcd_state_t            state,
  input  logic [pcd_pkg::TimeW-1:0]      now_ms,
  input  logic [pcd_pkg::PatW-1:0]       pattern,
  output pcd_pkg::pcd_state_t            state_nxt,
  output logic                           changed
);

  logic                          same;
  logic [pcd_pkg::CountW-1:0]    cnt_nxt;
  logic                          blink;
  logic [pcd_pkg::CountW-1:0]    req;
  logic [pcd_pkg::TimeW-1:0]     diff;
  logic                          allowed;

  assign same  = (pattern == state.cand_pat);
  assign blink = (pattern == pcd_pkg::PAT_SLOW_BLINK) || (pattern == pcd_pkg::PAT_FAST_BLINK);
  assign req   = blink ? cfg.blink_polls : cfg.quiet_polls;

  always_comb begin
    if (!same) begin
      cnt_nxt = pcd_pkg::CountW'(1);
    end else if (state.cand_cnt == pcd_pkg::COUNT_MAX) begin
      cnt_nxt = state.cand_cnt;
    end else begin
      cnt_nxt = state.cand_cnt + pcd_pkg::CountW'(1);
    end
  end

  // wrap-safe spacing: sign bit of (now - last - spacing)
  assign diff    = now_ms - state.chg_time
                   - {{(pcd_pkg::TimeW-pcd_pkg::SpacingW){1'b0}}, cfg.quiet_spacing};
  assign allowed = blink || !diff[pcd_pkg::TimeW-1];
  assign changed = (cnt_nxt >= req) && (pattern != state.report) && allowed;

  always_comb begin
    state_nxt          = state;
    state_nxt.cand_pat = pattern;
    state_nxt.cand_cnt = cnt_nxt;
    if (changed) begin
      state_nxt.report   = pattern;
      state_nxt.chg_time = now_ms;
    end
  end

endmodule

### dv/debounce_checker.sv
// Checker for the pattern change debouncer: predicts each result word and compares it
`timescale 1ns / 100ps

module debounce_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [pcd_pkg::TimeW-1:0] in_now_ms,
  input  logic [pcd_pkg::PatW-1:0]  in_pattern,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_changed,
  input  logic [pcd_pkg::PatW-1:0]  out_reported_pattern,
  input  logic [pcd_pkg::TimeW-1:0] out_change_time_ms,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [pcd_pkg::AddrW-1:0] cfg_paddr,
  input  logic [pcd_pkg::DataW-1:0] cfg_pwdata,
  input  logic                      cfg_pready,
  output int unsigned               words_due,
  output int unsigned               fail_count
);
  import pcd_pkg::*;

  typedef struct packed {
    logic             changed;
    logic [PatW-1:0]  pattern;
    logic [TimeW-1:0] change_ms;
  } report_word_t;

  pcd_cfg_t          cfg;
  logic [PatW-1:0]   cand_pat;
  logic [CountW-1:0] cand_cnt;
  logic [PatW-1:0]   shown_pat;
  logic [TimeW-1:0]  last_report_ms;

  report_word_t due_reports[$];
  int unsigned  errs = 0;

  // one poll through the debounce filter; updates the filter state
  function automatic report_word_t debounce_poll(input logic [TimeW-1:0] now_ms,
                                                 input logic [PatW-1:0]  pat);
    logic             blink;
    logic [CountW-1:0] need;
    logic [TimeW-1:0] slack;
    report_word_t     r;
    if (pat != cand_pat) begin
      cand_pat = pat;
      cand_cnt = CountW'(1);
    end else if (cand_cnt != COUNT_MAX) begin
      cand_cnt = cand_cnt + 1'b1;
    end
    blink = (cand_pat == PAT_SLOW_BLINK) || (cand_pat == PAT_FAST_BLINK);
    need = blink ? cfg.blink_polls : cfg.quiet_polls;
    r.changed = 1'b0;
    if (cand_cnt >= need && cand_pat != shown_pat) begin
      // wrap-safe: sign of (now - last - spacing) decides
      slack = now_ms - last_report_ms - {{(TimeW-SpacingW){1'b0}}, cfg.quiet_spacing};
      if (blink || !slack[TimeW-1]) begin
        shown_pat      = cand_pat;
        last_report_ms = now_ms;
        r.changed      = 1'b1;
      end
    end
    r.pattern   = shown_pat;
    r.change_ms = last_report_ms;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    report_word_t got;
    report_word_t want;
    if (!rst_n) begin
      cfg.quiet_spacing = QUIET_SPACING_RST;
      cfg.blink_polls   = BLINK_POLLS_RST;
      cfg.quiet_polls   = QUIET_POLLS_RST;
      cand_pat          = PAT_UNKNOWN;
      cand_cnt          = '0;
      shown_pat         = PAT_UNKNOWN;
      last_report_ms    = '0;
      due_reports.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[AddrW-1:2])
          REG_QUIET_SPACING: cfg.quiet_spacing = cfg_pwdata[SpacingW-1:0];
          REG_BLINK_POLLS:   cfg.blink_polls   = cfg_pwdata[CountW-1:0];
          REG_QUIET_POLLS:   cfg.quiet_polls   = cfg_pwdata[CountW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due_reports.push_back(debounce_poll(in_now_ms, in_pattern));
      end
      if (out_valid && !out_stall) begin
        got = {out_changed, out_reported_pattern, out_change_time_ms};
        if (due_reports.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected result word: changed=%0d pattern=%0d time=%h",
                     got.changed, got.pattern, got.change_ms);
          end
        end else begin
          want = due_reports.pop_front();
          if (got.changed !== want.changed || got.pattern !== want.pattern ||
              got.change_ms !== want.change_ms) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch: expected changed=%0d pattern=%0d time=%h",
                       want.changed, want.pattern, want.change_ms);
              $display("          got      changed=%0d pattern=%0d time=%h",
                       got.changed, got.pattern, got.change_ms);
            end
          end
        end
      end
    end
    words_due  <= due_reports.size();
    fail_count <= errs;
  end

endmodule

### dv/testbench.sv
// Top of the pattern change debouncer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import pcd_pkg::*;

  localparam logic [PatW-1:0] PAT_OFF      = 3'd1;
  localparam logic [PatW-1:0] PAT_SOLID    = 3'd2;
  // codes above fast blink are unused but still filtered as quiet patterns
  localparam logic [PatW-1:0] PAT_SPARE_LO = 3'd5;
  localparam logic [PatW-1:0] PAT_SPARE_MID = 3'd6;
  localparam logic [PatW-1:0] PAT_SPARE_HI = 3'd7;

  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [TimeW-1:0] in_now_ms = '0;
  logic [PatW-1:0]  in_pattern = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_changed;
  logic [PatW-1:0]  out_reported_pattern;
  logic [TimeW-1:0] out_change_time_ms;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [AddrW-1:0] cfg_paddr = '0;
  logic [DataW-1:0] cfg_pwdata = '0;
  logic [DataW-1:0] cfg_prdata;
  logic             cfg_pready;

  int unsigned words_due;
  int unsigned fail_count;
  int unsigned hold_reqs = 0;

  int unsigned      spacing_ms = QUIET_SPACING_RST;
  int unsigned      blink_need = BLINK_POLLS_RST;
  int unsigned      quiet_need = QUIET_POLLS_RST;
  logic [TimeW-1:0] poll_ms = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pattern_change_debouncer_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_now_ms           (in_now_ms),
    .in_pattern          (in_pattern),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_changed         (out_changed),
    .out_reported_pattern(out_reported_pattern),
    .out_change_time_ms  (out_change_time_ms),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  debounce_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_now_ms           (in_now_ms),
    .in_pattern          (in_pattern),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_changed         (out_changed),
    .out_reported_pattern(out_reported_pattern),
    .out_change_time_ms  (out_change_time_ms),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_pready          (cfg_pready),
    .words_due           (words_due),
    .fail_count          (fail_count)
  );

  // receiver: stall pattern of its own, plus a long hold-off on request
  initial begin : rx_pattern
    rx_mode_e    mode;
    int unsigned left;
    int unsigned hold;
    int unsigned seen;
    mode = RX_FREE;
    left = 0;
    hold = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold = 80;
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(10, 120);
      end
      left--;
      if (hold != 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= (left % 3 == 0);
        endcase
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [DataW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // upper bits carry noise; only the register's own width counts
  task automatic set_config(input int unsigned spacing, input int unsigned blink,
                            input int unsigned quiet);
    spacing_ms = spacing;
    blink_need = blink;
    quiet_need = quiet;
    reg_write(REG_QUIET_SPACING, ($urandom & 32'hFFFF_0000) | spacing);
    reg_write(REG_BLINK_POLLS, ($urandom & 32'hFFFF_FF00) | blink);
    reg_write(REG_QUIET_POLLS, ($urandom & 32'hFFFF_FF00) | quiet);
  endtask

  task automatic put_poll(input logic [TimeW-1:0] now_ms, input logic [PatW-1:0] pat);
    in_valid   <= 1'b1;
    in_now_ms  <= now_ms;
    in_pattern <= pat;
    do @(posedge clk); while (in_stall);
  endtask

  // the due count is a registered copy of the checker's queue size, so look only after the next edge
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  // runs of one pattern around the stable-poll thresholds, with noise in between
  task automatic run_random(input int unsigned n_items, input bit hold_off);
    int unsigned     sent;
    int unsigned     run_len;
    int unsigned     lim;
    int unsigned     burst;
    int unsigned     k;
    logic [PatW-1:0] pat;
    sent  = 0;
    burst = $urandom_range(1, 40);
    lim   = ((blink_need > quiet_need) ? blink_need : quiet_need) + 2;
    if (hold_off) begin
      hold_reqs <= hold_reqs + 1;
      burst = 120;  // keep offering words while the receiver holds off
    end
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        pat = PatW'($urandom_range(PAT_SPARE_LO, PAT_SPARE_HI));
      end else begin
        pat = PatW'($urandom_range(PAT_UNKNOWN, PAT_FAST_BLINK));
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3: run_len = 1;
        4: run_len = (lim > 200) ? $urandom_range(250, 300) : lim;  // count saturates
        default: run_len = $urandom_range(1, lim);
      endcase
      for (k = 0; k < run_len && sent < n_items; k++) begin
        case ($urandom_range(0, 31))
          0: poll_ms = $urandom;
          1: poll_ms = poll_ms + 32'h7FFF_FFF0 + $urandom_range(0, 32);
          default: poll_ms = poll_ms + $urandom_range(0, spacing_ms / 2 + 3);
        endcase
        put_poll(poll_ms, pat);
        sent++;
        burst--;
        if (burst == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 30);
        end
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: spacing 30, blink 1, quiet 2
    put_poll(32'd0, PAT_UNKNOWN);      // first unknown poll only raises the count
    put_poll(32'd5, PAT_SLOW_BLINK);
    put_poll(32'd6, PAT_FAST_BLINK);
    put_poll(32'd10, PAT_OFF);
    put_poll(32'd12, PAT_OFF);         // held back by spacing
    put_poll(32'd36, PAT_OFF);         // spacing met exactly
    put_poll(32'd40, PAT_SOLID);
    put_poll(32'd41, PAT_SOLID);
    put_poll(32'd66, PAT_SOLID);
    put_poll(32'd70, PAT_SPARE_LO);
    put_poll(32'd100, PAT_SPARE_LO);
    put_poll(32'd101, PAT_SPARE_HI);
    put_poll(32'd150, PAT_SPARE_HI);
    put_poll(32'h7FFF_FFF0, PAT_SOLID);
    put_poll(32'h7FFF_FFF1, PAT_SOLID);
    put_poll(32'hFFFF_FFF0, PAT_OFF);
    put_poll(32'hFFFF_FFF8, PAT_OFF);
    // timestamps wrap through zero
    put_poll(32'h0000_0005, PAT_UNKNOWN);
    put_poll(32'h0000_0010, PAT_UNKNOWN);
    put_poll(32'h0000_0016, PAT_UNKNOWN);
    put_poll(32'h0000_0017, PAT_SPARE_MID);
    put_poll(32'h0000_0018, PAT_SPARE_MID);
    put_poll(32'h8000_0030, PAT_SPARE_MID);
    poll_ms = 32'h8000_0030;
    drain;

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(0, 0, 0);
        1: set_config(16'hFFFF, 255, 255);
        2: set_config(1, 1, 1);
        3: set_config(QUIET_SPACING_RST, BLINK_POLLS_RST, QUIET_POLLS_RST);
        default: set_config($urandom_range(0, 1) ? $urandom_range(0, 16'hFFFF)
                                                 : $urandom_range(0, 100),
                            $urandom_range(1, 6), $urandom_range(1, 6));
      endcase
      case (ph)
        0: run_random(150, 1'b0);
        1: run_random(400, 1'b0);
        2, 3: run_random(200, ph == 2);
        default: run_random(190, ph == 5);
      endcase
      drain;
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : run_limit
    #800_000;
    $display("Verification failed");
    $finish;
  end

endmodule
